// ----- hw/rtl/bfha_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bfha_pkg
// Shared types and constants for the best-fit heap allocator.
// ----------------------------------------------------------------------------
package bfha_pkg;
    localparam int unsigned POOL_BYTES_DEF   = 4096;
    localparam int unsigned HEADER_BYTES_DEF = 4;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [11:0] req_bytes;
        logic [11:0] free_offset;
    } t_in_beat;

    typedef struct packed {
        logic        ok;
        logic [11:0] payload_offset;
    } t_out_beat;
endpackage
`default_nettype wire

// ----- hw/rtl/bfha_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bfha_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module bfha_ram #(
    parameter int unsigned WIDTH = 13,
    parameter int unsigned DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ----- hw/rtl/best_fit_heap_allocator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// best_fit_heap_allocator
// Best-fit allocator over an implicit block list held in one header RAM.
// ----------------------------------------------------------------------------
// One beat at a time. An allocate walks every block header, with a RAM read
// and then a decide step per block, then writes the split header and the
// used header. A free first reads the block header and writes it back
// positive, then walks the pool: a used block or the last block takes a
// read and a check, a free block with a block after it also has its
// neighbour read, and each merge adds a read of the neighbour, a write of
// the sum and a reread. A zero request or an out-of-range free answers in
// the cycle after the beat is taken. After the result is taken the block
// returns to idle and can take the next beat in the cycle after. The
// single-port header RAM sets this order of reads and writes. After reset
// entry 0 is written first; the block is ready after that. The result is
// held in an output register until taken.
// ----------------------------------------------------------------------------
module best_fit_heap_allocator #(
    parameter int unsigned POOL_BYTES   = bfha_pkg::POOL_BYTES_DEF,
    parameter int unsigned HEADER_BYTES = bfha_pkg::HEADER_BYTES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire bfha_pkg::t_in_beat i_data,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output bfha_pkg::t_out_beat     o_data
);
    localparam int unsigned AW = $clog2(POOL_BYTES);
    localparam int unsigned OW = (AW > 12) ? AW : 12;  // beat fields are 12 bits
    localparam int unsigned PW = OW + 2;   // position, room past pool end
    localparam int unsigned HW = OW + 2;   // signed header width
    localparam logic [PW-1:0] POOL_P = PW'(POOL_BYTES);
    localparam logic [PW-1:0] HDR_P  = PW'(HEADER_BYTES);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_A_RD, S_A_CHK, S_A_SPLIT, S_A_USED,
        S_F_MARK_RD, S_F_MARK_WR, S_F_RD, S_F_CHK, S_F_NRD, S_F_NCHK, S_OUT
    } t_state;

    t_state                r_state;
    logic [PW-1:0]         r_pos, r_next, r_best_pos;
    logic signed [HW-1:0]  r_h, r_best;
    logic                  r_found;
    logic [11:0]           r_req, r_off;
    bfha_pkg::t_out_beat   r_out;

    logic                  ram_we;
    logic [AW-1:0]         ram_addr;
    logic signed [HW-1:0]  ram_wdata, ram_rdata;
    logic signed [HW-1:0]  mag, need;
    logic [PW-1:0]         nxt;

    bfha_ram #(.WIDTH(HW), .DEPTH(POOL_BYTES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    assign mag  = ram_rdata[HW-1] ? -ram_rdata : ram_rdata;
    assign nxt  = r_pos + PW'(mag) + HDR_P;
    assign need = HW'({1'b0, r_req}) + HW'(HEADER_BYTES);

    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = r_pos[AW-1:0];
        ram_wdata = r_h;
        unique case (r_state)
            S_INIT: begin
                ram_we    = 1'b1;
                ram_addr  = '0;
                ram_wdata = HW'(POOL_BYTES - HEADER_BYTES);
            end
            S_A_SPLIT: begin
                ram_we    = 1'b1;
                ram_addr  = AW'(r_best_pos + HDR_P + PW'(r_req));
                ram_wdata = r_best - need;
            end
            S_A_USED: begin
                ram_we    = 1'b1;
                ram_addr  = r_best_pos[AW-1:0];
                ram_wdata = -HW'({1'b0, r_req});
            end
            S_F_MARK_WR: begin
                ram_we    = 1'b1;
                ram_addr  = AW'(PW'(r_off) - HDR_P);
                ram_wdata = mag;
            end
            S_F_MARK_RD: ram_addr = AW'(PW'(r_off) - HDR_P);
            S_F_NRD:     ram_addr = r_next[AW-1:0];
            S_F_NCHK: begin
                ram_we    = !ram_rdata[HW-1];
                ram_wdata = r_h + HW'(HEADER_BYTES) + ram_rdata;
            end
            default: ;
        endcase
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            unique case (r_state)
                S_INIT: r_state <= S_IDLE;
                S_IDLE: begin
                    if (i_valid) begin
                        r_req   <= i_data.req_bytes;
                        r_off   <= i_data.free_offset;
                        r_pos   <= '0;
                        r_found <= 1'b0;
                        if (i_data.cmd == bfha_pkg::CMD_ALLOC) begin
                            if (i_data.req_bytes == '0) begin
                                r_out   <= '0;
                                r_state <= S_OUT;
                            end else begin
                                r_state <= S_A_RD;
                            end
                        end else if (PW'(i_data.free_offset) < HDR_P ||
                                     PW'(i_data.free_offset) - HDR_P >= POOL_P) begin
                            r_out   <= '{ok: 1'b1, payload_offset: '0};
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_F_MARK_RD;
                        end
                    end
                end
                S_A_RD: r_state <= S_A_CHK;
                S_A_CHK: begin
                    if (ram_rdata > need && (!r_found || ram_rdata < r_best)) begin
                        r_best     <= ram_rdata;
                        r_best_pos <= r_pos;
                        r_found    <= 1'b1;
                    end
                    r_pos <= nxt;
                    if (nxt < POOL_P) begin
                        r_state <= S_A_RD;
                    end else if (r_found ||
                                 (ram_rdata > need)) begin
                        r_state <= S_A_SPLIT;
                    end else begin
                        r_out   <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_A_SPLIT: r_state <= S_A_USED;
                S_A_USED: begin
                    r_out   <= '{ok: 1'b1,
                                 payload_offset: 12'(r_best_pos + HDR_P)};
                    r_state <= S_OUT;
                end
                S_F_MARK_RD: r_state <= S_F_MARK_WR;
                S_F_MARK_WR: r_state <= S_F_RD;
                S_F_RD:      r_state <= S_F_CHK;
                S_F_CHK: begin
                    r_h    <= ram_rdata;
                    r_next <= nxt;
                    if (!ram_rdata[HW-1] && nxt < POOL_P) begin
                        r_state <= S_F_NRD;
                    end else if (nxt < POOL_P) begin
                        r_pos   <= nxt;
                        r_state <= S_F_RD;
                    end else begin
                        r_out   <= '{ok: 1'b1, payload_offset: '0};
                        r_state <= S_OUT;
                    end
                end
                S_F_NRD: r_state <= S_F_NCHK;
                S_F_NCHK: begin
                    // merged: reread same block; else step to neighbour
                    if (ram_rdata[HW-1]) begin
                        r_pos <= r_next;
                    end
                    r_state <= S_F_RD;
                end
                S_OUT: if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    ap_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid) else $error("ready and valid together");
    ap_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.ok) |-> o_data.payload_offset == '0)
        else $error("failed alloc with offset");
    ap_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_data)))
        else $error("result dropped");
    ap_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_A_RD || r_state == S_F_RD) |-> r_pos < POOL_P)
        else $error("walk past pool");
endmodule
`default_nettype wire

// ----- tb/tb_best_fit_heap_allocator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_best_fit_heap_allocator
// Self-checking bench for the best-fit heap allocator.
// ----------------------------------------------------------------------------
// A driver sends allocate and free beats from a queue, and a monitor takes
// result beats with random stalls. A behavioral heap model, kept in the
// bench, predicts each result. Frees use only offsets that are or were
// granted, or offsets that are out of range. Never-granted in-range offsets
// are not sent.
// ----------------------------------------------------------------------------
module tb_best_fit_heap_allocator;
    localparam int POOL = 4096;
    localparam int HDR  = 4;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    bfha_pkg::t_in_beat  i_data;
    logic                o_valid;
    logic                i_ready;
    bfha_pkg::t_out_beat o_data;

    best_fit_heap_allocator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    // Heap model state: one signed header per byte offset.
    int                  heap_hdr [POOL];
    bfha_pkg::t_in_beat  pending_beats [$];
    bfha_pkg::t_out_beat expected_results [$];
    int                  live_offsets [$];    // offsets granted and not yet freed
    int                  errors = 0;
    int                  hold_off;            // sender waits for drain while set

    function automatic int iabs(int v);
        return v < 0 ? -v : v;
    endfunction

    // Best-fit allocate on the model; returns the granted offset or -1.
    function automatic int heap_alloc(int req);
        int pos;
        int best_pos;
        int best_len;
        int h;
        bit found;
        pos = 0;
        best_pos = 0;
        best_len = 0;
        found = 0;
        if (req == 0) return -1;
        while (pos < POOL) begin
            h = heap_hdr[pos];
            if (h > req + HDR && (!found || h < best_len)) begin
                best_len = h;
                best_pos = pos;
                found = 1;
            end
            pos += iabs(h) + HDR;
        end
        if (!found) return -1;
        heap_hdr[best_pos + HDR + req] = best_len - req - HDR;
        heap_hdr[best_pos] = -req;
        return best_pos + HDR;
    endfunction

    // Free plus coalesce pass; the bounds test guards the neighbour read.
    function automatic void heap_free(int off);
        int pos;
        int h;
        int nxt;
        pos = 0;
        if (off < HDR || off - HDR >= POOL) return;
        heap_hdr[off - HDR] = iabs(heap_hdr[off - HDR]);
        while (pos < POOL) begin
            h = heap_hdr[pos];
            nxt = pos + iabs(h) + HDR;
            if (h >= 0 && nxt < POOL && heap_hdr[nxt] >= 0) begin
                heap_hdr[pos] = h + HDR + heap_hdr[nxt];
            end else begin
                pos = nxt;
            end
        end
    endfunction

    function automatic bfha_pkg::t_out_beat predict_result(bfha_pkg::t_in_beat b);
        bfha_pkg::t_out_beat r;
        int g;
        r = '0;
        if (b.cmd == bfha_pkg::CMD_ALLOC) begin
            g = heap_alloc(int'(b.req_bytes));
            if (g >= 0) begin
                r.ok = 1'b1;
                r.payload_offset = g[11:0];
            end
        end else begin
            heap_free(int'(b.free_offset));
            r.ok = 1'b1;
        end
        return r;
    endfunction

    // Gap length: mostly 0..2, sometimes up to 40.
    function automatic int rand_gap();
        if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
        return $urandom_range(3, 40);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Driver: one beat in flight on the input side, random gaps between beats.
    int drv_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_data  <= '0;
            drv_gap <= 0;
        end else if (i_valid && !o_ready) begin
            // hold the beat until it is taken
        end else if (drv_gap > 0) begin
            i_valid <= 1'b0;
            drv_gap <= drv_gap - 1;
        end else if (pending_beats.size() > 0 && !hold_off) begin
            bfha_pkg::t_in_beat b;
            b = pending_beats.pop_front();
            expected_results.push_back(predict_result(b));
            i_data  <= b;
            i_valid <= 1'b1;
            drv_gap <= rand_gap();
        end else begin
            i_valid <= 1'b0;
        end
    end

    // Monitor: random ready gaps, field-by-field compare on each beat.
    int mon_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            mon_gap <= 0;
        end else if (o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result ok=%0b off=%0d", $time,
                         o_data.ok, o_data.payload_offset);
                errors++;
            end else begin
                bfha_pkg::t_out_beat e;
                e = expected_results.pop_front();
                if (e.ok !== o_data.ok) begin
                    $display("%0t: ok mismatch exp=%0b got=%0b", $time,
                             e.ok, o_data.ok);
                    errors++;
                end
                if (e.payload_offset !== o_data.payload_offset) begin
                    $display("%0t: offset mismatch exp=%0d got=%0d", $time,
                             e.payload_offset, o_data.payload_offset);
                    errors++;
                end
            end
            i_ready <= 1'b0;
            mon_gap <= rand_gap();
        end else if (mon_gap > 0) begin
            i_ready <= 1'b0;
            mon_gap <= mon_gap - 1;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Build one beat; free offsets come from the planning tasks, so no unwritten header is read.
    task automatic add_alloc(int req);
        bfha_pkg::t_in_beat b;
        b = '0;
        b.cmd = bfha_pkg::CMD_ALLOC;
        b.req_bytes = req[11:0];
        b.free_offset = 12'($urandom);
        pending_beats.push_back(b);
    endtask

    task automatic add_free(int off);
        bfha_pkg::t_in_beat b;
        b = '0;
        b.cmd = bfha_pkg::CMD_FREE;
        b.free_offset = off[11:0];
        b.req_bytes = 12'($urandom);
        pending_beats.push_back(b);
    endtask

    // Track which offsets will be live, on a shadow of the model.
    int shadow_hdr [POOL];

    function automatic int shadow_alloc(int req);
        int g;
        int save [POOL];
        save = heap_hdr;
        heap_hdr = shadow_hdr;
        g = heap_alloc(req);
        shadow_hdr = heap_hdr;
        heap_hdr = save;
        return g;
    endfunction

    function automatic void shadow_free(int off);
        int save [POOL];
        save = heap_hdr;
        heap_hdr = shadow_hdr;
        heap_free(off);
        shadow_hdr = heap_hdr;
        heap_hdr = save;
    endfunction

    task automatic plan_alloc(int req);
        int g;
        g = shadow_alloc(req);
        if (g >= 0) live_offsets.push_back(g);
        add_alloc(req);
    endtask

    task automatic plan_free_live(int idx, bit keep);
        int off;
        off = live_offsets[idx];
        if (!keep) live_offsets.delete(idx);
        shadow_free(off);
        add_free(off);
    endtask

    task automatic plan_free_raw(int off);
        shadow_free(off);
        add_free(off);
    endtask

    task automatic drain();
        while (pending_beats.size() > 0 || expected_results.size() > 0 || i_valid)
            @(posedge i_clk);
    endtask

    initial begin
        int n;
        int r;
        foreach (heap_hdr[k]) heap_hdr[k] = 0;
        heap_hdr[0] = POOL - HDR;
        shadow_hdr = heap_hdr;
        hold_off = 0;
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero request, too large, exact-fit boundary, out-of-range
        // frees, double free, merge at pool end, all-ones field bits.
        plan_alloc(0);
        plan_alloc(4095);
        plan_alloc(POOL - 2 * HDR);        // need equals block size: fails
        plan_alloc(POOL - 2 * HDR - 1);    // largest that fits
        plan_alloc(1);                     // pool full of one block: fails
        plan_free_live(0, 1);
        plan_free_raw(live_offsets[0]);    // double free
        void'(live_offsets.pop_front());
        plan_free_raw(0);                  // below header size
        plan_free_raw(3);
        plan_alloc(1);
        plan_alloc(100);
        plan_alloc(7);
        plan_alloc(2048);
        plan_alloc(1);
        plan_free_live(1, 0);
        plan_free_live(0, 0);              // adjacent frees merge
        plan_alloc(50);
        plan_free_live(live_offsets.size() - 1, 0);
        while (live_offsets.size() > 0) plan_free_live(0, 0);  // back to one block

        // Wait until every result is back, then pause the sender.
        drain();
        hold_off = 1;
        repeat (3) @(posedge i_clk);
        hold_off = 0;

        // Random: mostly small requests, some large or zero ones, frees of live blocks, out-of-range frees.
        for (n = 0; n < 1750; n++) begin
            r = $urandom_range(0, 99);
            if (live_offsets.size() > 0 && r < 45) begin
                plan_free_live($urandom_range(0, live_offsets.size() - 1), 0);
            end else if (r < 48) begin
                plan_free_raw($urandom_range(0, HDR - 1));
            end else if (r < 52) begin
                plan_alloc($urandom_range(1000, 4095));
            end else if (r < 54) begin
                plan_alloc(0);
            end else begin
                plan_alloc($urandom_range(1, 200));
            end
            if (live_offsets.size() > 40 && r < 70)
                plan_free_live($urandom_range(0, live_offsets.size() - 1), 0);
        end
        drain();
        repeat (200) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("[best_fit_heap_allocator] OK");
        end else begin
            $display("[best_fit_heap_allocator] ERROR");
        end
        $finish;
    end

    // Watchdog: reports an error and stops the run if it has not finished in time.
    initial begin
        #400000000;
        $display("[best_fit_heap_allocator] ERROR");
        $finish;
    end
endmodule
`default_nettype wire

// ----- filelist.f -----
hw/rtl/bfha_pkg.sv
hw/rtl/bfha_ram.sv
hw/rtl/best_fit_heap_allocator.sv
tb/tb_best_fit_heap_allocator.sv
